>>> rtl/core/ngga_pkg.sv
// ----------------------------------------------------------------------------
// ngga_pkg: shared constants and helpers for the GGA sentence parser.
// Holds character codes, field numbers, saturation limits and the decimal
// scaling function that is used when a numeric field is closed.
// ----------------------------------------------------------------------------
package ngga_pkg;

    // Character codes seen in the byte stream.
    localparam logic [7:0] ASCII_COMMA = 8'h2C;
    localparam logic [7:0] ASCII_LF    = 8'h0A;
    localparam logic [7:0] ASCII_DOT   = 8'h2E;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_S     = 8'h53;
    localparam logic [7:0] ASCII_W     = 8'h57;

    // Field numbers within a GGA sentence.
    localparam logic [3:0] FIELD_HEADER   = 4'd0;
    localparam logic [3:0] FIELD_LAT      = 4'd2;
    localparam logic [3:0] FIELD_LAT_HEMI = 4'd3;
    localparam logic [3:0] FIELD_LON      = 4'd4;
    localparam logic [3:0] FIELD_LON_HEMI = 4'd5;
    localparam logic [3:0] FIELD_FIX      = 4'd6;
    localparam logic [3:0] FIELD_SATS     = 4'd7;
    localparam logic [3:0] FIELD_HDOP     = 4'd8;
    localparam logic [3:0] FIELD_ALT      = 4'd9;
    localparam logic [3:0] COUNT_MAX      = 4'd15;

    // Configuration register indexes.
    localparam logic CFG_ALPHA  = 1'b0;
    localparam logic CFG_THRESH = 1'b1;

    // Reset values of the configuration registers and the alpha limit.
    localparam logic [16:0] ALPHA_RESET  = 17'd52429;
    localparam logic [16:0] ALPHA_MAX    = 17'd65536;
    localparam logic [26:0] THRESH_RESET = 27'd600000;

    // Saturation limits, minutes per degree and the header length.
    localparam logic [29:0] DIGIT_CAP     = 30'd999999999;
    localparam logic [29:0] DIGIT_PRE_CAP = 30'd99999999;
    localparam logic [44:0] LAT_CAP       = 45'd54000000;
    localparam logic [44:0] LON_CAP       = 45'd108000000;
    localparam logic [43:0] HDOP_CAP      = 44'd9999;
    localparam logic [43:0] ALT_POS_CAP   = 44'd999999;
    localparam logic [43:0] ALT_NEG_CAP   = 44'd99999;
    localparam logic [44:0] MIN_PER_DEG   = 45'd600000;
    localparam logic [2:0]  HEADER_LEN    = 3'd6;

    // Characters of the accepted sentence header.
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        case (idx)
            3'd0:    return 8'h24;
            3'd1:    return 8'h47;
            3'd2:    return 8'h50;
            3'd3:    return 8'h47;
            3'd4:    return 8'h47;
            3'd5:    return 8'h41;
            default: return 8'h00;
        endcase
    endfunction

    // Pads missing fraction digits: acc times ten to the pad, capped at 10^4.
    function automatic logic [43:0] scale_dec(input logic [29:0] acc, input logic [2:0] pad);
        logic [43:0] wide;
        wide = {14'd0, acc};
        case (pad)
            3'd0:    return wide;
            3'd1:    return wide * 44'd10;
            3'd2:    return wide * 44'd100;
            3'd3:    return wide * 44'd1000;
            default: return wide * 44'd10000;
        endcase
    endfunction

endpackage

>>> rtl/core/nmea_gga_parse_filter.sv
// ----------------------------------------------------------------------------
// nmea_gga_parse_filter: GGA sentence parser with position smoothing.
// Parses GGA lines from a byte stream and reports one position per line.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one character per request; a character is taken in
//   every cycle while s_ready is high. Lines end at a line feed and fields
//   are split at commas. For each line whose header is the GGA header, one
//   request appears on the m_ channel carrying the parsed position, fix,
//   satellites, HDOP and altitude, the smoothed position and an accept flag.
//   Pipeline: after the line feed is taken, the result passes four stages,
//   sample capture, difference, weight multiply and filter update, followed
//   by the output register. Throughput is one byte a cycle while not stalled.
//   A stalled receiver holds the output register; bytes keep being taken
//   until a second finished line reaches the last stage, and only then does
//   s_ready drop until the output is free.
//   Reset (synchronous, active low) clears the parser, the filter state and
//   loads the configuration defaults. Configuration writes through cfg_wr_en
//   are taken at once and are meant for idle periods only.
// ----------------------------------------------------------------------------
module nmea_gga_parse_filter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [26:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [26:0] m_latitude,
    output logic signed [27:0] m_longitude,
    output logic [3:0]         m_fix_quality,
    output logic [6:0]         m_satellite_count,
    output logic [13:0]        m_hdop_hundredths,
    output logic signed [20:0] m_altitude_dm,
    output logic signed [26:0] m_smoothed_lat,
    output logic signed [27:0] m_smoothed_lon,
    output logic               m_accepted
);

    // Configuration.
    logic [16:0] alpha_reg;
    logic [26:0] thresh_reg;

    // Parser state.
    logic [2:0]         header_match_reg, header_match_next;
    logic               header_ok_reg, header_ok_next;
    logic [3:0]         field_index_reg, field_index_next;
    logic [3:0]         char_in_field_reg, char_in_field_next;
    logic [2:0]         fraction_digits_reg, fraction_digits_next;
    logic               after_point_reg, after_point_next;
    logic [7:0]         degree_acc_reg, degree_acc_next;
    logic [29:0]        number_acc_reg, number_acc_next;
    logic               negative_number_reg, negative_number_next;
    logic               num_stop_reg, num_stop_next;
    logic signed [26:0] held_lat_reg, held_lat_next;
    logic signed [27:0] held_lon_reg, held_lon_next;
    logic [3:0]         held_fix_reg, held_fix_next;
    logic [6:0]         held_sats_reg, held_sats_next;
    logic [13:0]        held_hdop_reg, held_hdop_next;
    logic signed [20:0] held_alt_reg, held_alt_next;

    // Filter state.
    logic signed [26:0] filt_lat_reg;
    logic signed [27:0] filt_lon_reg;

    // Handshake and byte decode.
    logic       adv_en;
    logic       in_acc;
    logic       is_digit;
    logic [3:0] digit_val;
    logic       hok_eff;
    logic       line_done;
    logic [1:0] deg_width;
    logic [2:0] frac_limit;
    logic       stop_now;
    logic [11:0] deg_wide;
    logic [33:0] num_wide;

    // Field closing values.
    logic [44:0]        lat_sum;
    logic [44:0]        lon_sum;
    logic [43:0]        hdop_wide;
    logic [43:0]        alt_wide;
    logic signed [26:0] fin_lat;
    logic signed [27:0] fin_lon;
    logic [3:0]         fin_fix;
    logic [6:0]         fin_sats;
    logic [13:0]        fin_hdop;
    logic signed [20:0] fin_alt;

    // Sample taken at the end of a line.
    logic signed [26:0] smp_lat;
    logic signed [27:0] smp_lon;
    logic [3:0]         smp_fix;
    logic [6:0]         smp_sats;
    logic [13:0]        smp_hdop;
    logic signed [20:0] smp_alt;

    // Pipeline stages.
    logic               r1_valid_reg, r2_valid_reg, r3_valid_reg, r4_valid_reg;
    logic signed [26:0] r1_lat_reg, r2_lat_reg, r3_lat_reg, r4_lat_reg;
    logic signed [27:0] r1_lon_reg, r2_lon_reg, r3_lon_reg, r4_lon_reg;
    logic [3:0]         r1_fix_reg, r2_fix_reg, r3_fix_reg, r4_fix_reg;
    logic [6:0]         r1_sats_reg, r2_sats_reg, r3_sats_reg, r4_sats_reg;
    logic [13:0]        r1_hdop_reg, r2_hdop_reg, r3_hdop_reg, r4_hdop_reg;
    logic signed [20:0] r1_alt_reg, r2_alt_reg, r3_alt_reg, r4_alt_reg;
    logic signed [27:0] diff_lat_reg;
    logic signed [28:0] diff_lon_reg;
    logic signed [45:0] prod_lat_reg;
    logic signed [46:0] prod_lon_reg;

    // Filter update and compare.
    logic signed [45:0] rnd_lat;
    logic signed [46:0] rnd_lon;
    logic signed [45:0] step_lat;
    logic signed [46:0] step_lon;
    logic signed [27:0] mix_lat;
    logic signed [28:0] mix_lon;
    logic signed [27:0] dev_lat;
    logic signed [28:0] dev_lon;
    logic [27:0]        abs_lat;
    logic [28:0]        abs_lon;
    logic               out_load;

    // Output register.
    logic               out_valid_reg;
    logic signed [26:0] out_lat_reg;
    logic signed [27:0] out_lon_reg;
    logic [3:0]         out_fix_reg;
    logic [6:0]         out_sats_reg;
    logic [13:0]        out_hdop_reg;
    logic signed [20:0] out_alt_reg;
    logic signed [26:0] out_slat_reg;
    logic signed [27:0] out_slon_reg;
    logic               out_acc_reg;

    // Everything moves unless a finished line is blocked at the last stage.
    assign adv_en   = !(r4_valid_reg && out_valid_reg && !m_ready);
    assign s_ready  = adv_en;
    assign in_acc   = s_valid && adv_en;
    assign out_load = r4_valid_reg && adv_en;

    assign is_digit  = (s_rx_byte >= ngga_pkg::ASCII_ZERO) && (s_rx_byte <= ngga_pkg::ASCII_NINE);
    assign digit_val = 4'(s_rx_byte - ngga_pkg::ASCII_ZERO);

    // Closing values of the current numeric field.
    always_comb begin
        lat_sum   = {37'd0, degree_acc_reg} * ngga_pkg::MIN_PER_DEG
                  + {1'b0, ngga_pkg::scale_dec(number_acc_reg, 3'(3'd4 - fraction_digits_reg))};
        lon_sum   = lat_sum;
        hdop_wide = ngga_pkg::scale_dec(number_acc_reg, 3'(3'd2 - fraction_digits_reg));
        alt_wide  = ngga_pkg::scale_dec(number_acc_reg, 3'(3'd1 - fraction_digits_reg));
        fin_lat   = (lat_sum > ngga_pkg::LAT_CAP) ? $signed(ngga_pkg::LAT_CAP[26:0])
                                                : $signed(lat_sum[26:0]);
        fin_lon   = (lon_sum > ngga_pkg::LON_CAP) ? $signed(ngga_pkg::LON_CAP[27:0])
                                                : $signed(lon_sum[27:0]);
        fin_fix   = (number_acc_reg > 30'd9) ? 4'd9 : number_acc_reg[3:0];
        fin_sats  = (number_acc_reg > 30'd99) ? 7'd99 : number_acc_reg[6:0];
        fin_hdop  = (hdop_wide > ngga_pkg::HDOP_CAP) ? ngga_pkg::HDOP_CAP[13:0] : hdop_wide[13:0];
        if (negative_number_reg) begin
            fin_alt = (alt_wide > ngga_pkg::ALT_NEG_CAP) ? -$signed(ngga_pkg::ALT_NEG_CAP[20:0])
                                                       : -$signed(alt_wide[20:0]);
        end else begin
            fin_alt = (alt_wide > ngga_pkg::ALT_POS_CAP) ? $signed(ngga_pkg::ALT_POS_CAP[20:0])
                                                       : $signed(alt_wide[20:0]);
        end
    end

    // Byte parser: header match, field split and number accumulation.
    always_comb begin
        header_match_next    = header_match_reg;
        header_ok_next       = header_ok_reg;
        field_index_next     = field_index_reg;
        char_in_field_next   = char_in_field_reg;
        fraction_digits_next = fraction_digits_reg;
        after_point_next     = after_point_reg;
        degree_acc_next      = degree_acc_reg;
        number_acc_next      = number_acc_reg;
        negative_number_next = negative_number_reg;
        num_stop_next        = num_stop_reg;
        held_lat_next        = held_lat_reg;
        held_lon_next        = held_lon_reg;
        held_fix_next        = held_fix_reg;
        held_sats_next       = held_sats_reg;
        held_hdop_next       = held_hdop_reg;
        held_alt_next        = held_alt_reg;
        line_done            = 1'b0;
        stop_now             = num_stop_reg;
        deg_wide             = {4'd0, degree_acc_reg} * 12'd10 + {8'd0, digit_val};
        num_wide             = {4'd0, number_acc_reg} * 34'd10 + {30'd0, digit_val};
        hok_eff = (field_index_reg == ngga_pkg::FIELD_HEADER)
                ? (header_match_reg == ngga_pkg::HEADER_LEN && char_in_field_reg == 4'd6)
                : header_ok_reg;

        case (field_index_reg)
            ngga_pkg::FIELD_LAT: deg_width = 2'd2;
            ngga_pkg::FIELD_LON: deg_width = 2'd3;
            default:             deg_width = 2'd0;
        endcase
        case (field_index_reg)
            ngga_pkg::FIELD_LAT,
            ngga_pkg::FIELD_LON:  frac_limit = 3'd4;
            ngga_pkg::FIELD_HDOP: frac_limit = 3'd2;
            ngga_pkg::FIELD_ALT:  frac_limit = 3'd1;
            default:              frac_limit = 3'd0;
        endcase

        smp_lat  = held_lat_reg;
        smp_lon  = held_lon_reg;
        smp_fix  = held_fix_reg;
        smp_sats = held_sats_reg;
        smp_hdop = held_hdop_reg;
        smp_alt  = held_alt_reg;

        if (in_acc) begin
            if (s_rx_byte == ngga_pkg::ASCII_COMMA || s_rx_byte == ngga_pkg::ASCII_LF) begin
                // Close the field that the delimiter ends.
                if (hok_eff) begin
                    case (field_index_reg)
                        ngga_pkg::FIELD_LAT:  held_lat_next  = fin_lat;
                        ngga_pkg::FIELD_LON:  held_lon_next  = fin_lon;
                        ngga_pkg::FIELD_FIX:  held_fix_next  = fin_fix;
                        ngga_pkg::FIELD_SATS: held_sats_next = fin_sats;
                        ngga_pkg::FIELD_HDOP: held_hdop_next = fin_hdop;
                        ngga_pkg::FIELD_ALT:  held_alt_next  = fin_alt;
                        default: ;
                    endcase
                end
                smp_lat  = held_lat_next;
                smp_lon  = held_lon_next;
                smp_fix  = held_fix_next;
                smp_sats = held_sats_next;
                smp_hdop = held_hdop_next;
                smp_alt  = held_alt_next;

                char_in_field_next   = 4'd0;
                fraction_digits_next = 3'd0;
                after_point_next     = 1'b0;
                degree_acc_next      = 8'd0;
                number_acc_next      = 30'd0;
                negative_number_next = 1'b0;
                num_stop_next        = 1'b0;
                if (s_rx_byte == ngga_pkg::ASCII_COMMA) begin
                    header_ok_next = hok_eff;
                    if (field_index_reg != ngga_pkg::COUNT_MAX) begin
                        field_index_next = field_index_reg + 4'd1;
                    end
                end else begin
                    // End of line: emit for a GGA line and start afresh.
                    line_done         = hok_eff;
                    header_match_next = 3'd0;
                    header_ok_next    = 1'b0;
                    field_index_next  = 4'd0;
                    held_lat_next     = '0;
                    held_lon_next     = '0;
                    held_fix_next     = '0;
                    held_sats_next    = '0;
                    held_hdop_next    = '0;
                    held_alt_next     = '0;
                end
            end else begin
                if (field_index_reg == ngga_pkg::FIELD_HEADER) begin
                    // Header characters must match in order.
                    if (char_in_field_reg < 4'd6 && {1'b0, header_match_reg} == char_in_field_reg
                        && s_rx_byte == ngga_pkg::hdr_char(char_in_field_reg[2:0])) begin
                        header_match_next = header_match_reg + 3'd1;
                    end
                end else if (field_index_reg == ngga_pkg::FIELD_LAT_HEMI) begin
                    if (char_in_field_reg == 4'd0 && s_rx_byte == ngga_pkg::ASCII_S) begin
                        held_lat_next = -held_lat_reg;
                    end
                end else if (field_index_reg == ngga_pkg::FIELD_LON_HEMI) begin
                    if (char_in_field_reg == 4'd0 && s_rx_byte == ngga_pkg::ASCII_W) begin
                        held_lon_next = -held_lon_reg;
                    end
                end else if (field_index_reg inside {ngga_pkg::FIELD_LAT, ngga_pkg::FIELD_LON,
                                                     [ngga_pkg::FIELD_FIX:ngga_pkg::FIELD_ALT]})
                begin
                    // Minutes restart after the degree part, whatever stopped it.
                    if (deg_width != 2'd0 && char_in_field_reg == {2'd0, deg_width}) begin
                        stop_now = 1'b0;
                    end
                    num_stop_next = stop_now;
                    if (char_in_field_reg < {2'd0, deg_width}) begin
                        if (!stop_now && is_digit) begin
                            degree_acc_next = (deg_wide > 12'd255) ? 8'd255 : deg_wide[7:0];
                        end else begin
                            num_stop_next = 1'b1;
                        end
                    end else if (!stop_now) begin
                        if (is_digit) begin
                            if (!after_point_reg) begin
                                number_acc_next = (number_acc_reg > ngga_pkg::DIGIT_PRE_CAP)
                                                ? ngga_pkg::DIGIT_CAP : num_wide[29:0];
                            end else if (fraction_digits_reg < frac_limit) begin
                                // A fraction digit wraps at 32 bits before the cap applies.
                                number_acc_next = (num_wide[31:0] > {2'd0, ngga_pkg::DIGIT_CAP})
                                                ? ngga_pkg::DIGIT_CAP : num_wide[29:0];
                                fraction_digits_next = fraction_digits_reg + 3'd1;
                            end
                        end else if (s_rx_byte == ngga_pkg::ASCII_DOT && frac_limit != 3'd0
                                     && !after_point_reg) begin
                            after_point_next = 1'b1;
                        end else if (s_rx_byte == ngga_pkg::ASCII_MINUS
                                     && field_index_reg == ngga_pkg::FIELD_ALT
                                     && char_in_field_reg == 4'd0) begin
                            negative_number_next = 1'b1;
                        end else begin
                            num_stop_next = 1'b1;
                        end
                    end
                end
                if (char_in_field_reg != ngga_pkg::COUNT_MAX) begin
                    char_in_field_next = char_in_field_reg + 4'd1;
                end
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= ngga_pkg::ALPHA_RESET;
            thresh_reg <= ngga_pkg::THRESH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ngga_pkg::CFG_ALPHA: begin
                    alpha_reg <= (cfg_wr_data[16:0] > ngga_pkg::ALPHA_MAX || cfg_wr_data[26:17] != '0)
                               && cfg_wr_data[16:0] > ngga_pkg::ALPHA_MAX
                               ? ngga_pkg::ALPHA_MAX : cfg_wr_data[16:0];
                end
                ngga_pkg::CFG_THRESH: thresh_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_match_reg    <= '0;
            header_ok_reg       <= 1'b0;
            field_index_reg     <= '0;
            char_in_field_reg   <= '0;
            fraction_digits_reg <= '0;
            after_point_reg     <= 1'b0;
            degree_acc_reg      <= '0;
            number_acc_reg      <= '0;
            negative_number_reg <= 1'b0;
            num_stop_reg        <= 1'b0;
            held_lat_reg        <= '0;
            held_lon_reg        <= '0;
            held_fix_reg        <= '0;
            held_sats_reg       <= '0;
            held_hdop_reg       <= '0;
            held_alt_reg        <= '0;
        end else begin
            header_match_reg    <= header_match_next;
            header_ok_reg       <= header_ok_next;
            field_index_reg     <= field_index_next;
            char_in_field_reg   <= char_in_field_next;
            fraction_digits_reg <= fraction_digits_next;
            after_point_reg     <= after_point_next;
            degree_acc_reg      <= degree_acc_next;
            number_acc_reg      <= number_acc_next;
            negative_number_reg <= negative_number_next;
            num_stop_reg        <= num_stop_next;
            held_lat_reg        <= held_lat_next;
            held_lon_reg        <= held_lon_next;
            held_fix_reg        <= held_fix_next;
            held_sats_reg       <= held_sats_next;
            held_hdop_reg       <= held_hdop_next;
            held_alt_reg        <= held_alt_next;
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            r3_valid_reg <= 1'b0;
            r4_valid_reg <= 1'b0;
        end else if (adv_en) begin
            r1_valid_reg <= line_done;
            r2_valid_reg <= r1_valid_reg;
            r3_valid_reg <= r2_valid_reg;
            r4_valid_reg <= r3_valid_reg;
        end
    end

    // Pipeline payload: sample, difference to the filter, weighted difference.
    always_ff @(posedge aclk) begin
        if (adv_en) begin
            r1_lat_reg   <= smp_lat;
            r1_lon_reg   <= smp_lon;
            r1_fix_reg   <= smp_fix;
            r1_sats_reg  <= smp_sats;
            r1_hdop_reg  <= smp_hdop;
            r1_alt_reg   <= smp_alt;
            r2_lat_reg   <= r1_lat_reg;
            r2_lon_reg   <= r1_lon_reg;
            r2_fix_reg   <= r1_fix_reg;
            r2_sats_reg  <= r1_sats_reg;
            r2_hdop_reg  <= r1_hdop_reg;
            r2_alt_reg   <= r1_alt_reg;
            diff_lat_reg <= 28'(r1_lat_reg) - 28'(filt_lat_reg);
            diff_lon_reg <= 29'(r1_lon_reg) - 29'(filt_lon_reg);
            r3_lat_reg   <= r2_lat_reg;
            r3_lon_reg   <= r2_lon_reg;
            r3_fix_reg   <= r2_fix_reg;
            r3_sats_reg  <= r2_sats_reg;
            r3_hdop_reg  <= r2_hdop_reg;
            r3_alt_reg   <= r2_alt_reg;
            prod_lat_reg <= 46'(diff_lat_reg) * 46'($signed({1'b0, alpha_reg}));
            prod_lon_reg <= 47'(diff_lon_reg) * 47'($signed({1'b0, alpha_reg}));
            r4_lat_reg   <= r3_lat_reg;
            r4_lon_reg   <= r3_lon_reg;
            r4_fix_reg   <= r3_fix_reg;
            r4_sats_reg  <= r3_sats_reg;
            r4_hdop_reg  <= r3_hdop_reg;
            r4_alt_reg   <= r3_alt_reg;
        end
    end

    // Filter step: old plus the weighted difference, rounded half upward.
    always_comb begin
        rnd_lat  = prod_lat_reg + 46'sd32768;
        rnd_lon  = prod_lon_reg + 47'sd32768;
        step_lat = rnd_lat >>> 16;
        step_lon = rnd_lon >>> 16;
        mix_lat  = 28'(filt_lat_reg) + step_lat[27:0];
        mix_lon  = 29'(filt_lon_reg) + step_lon[28:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_lat_reg <= '0;
            filt_lon_reg <= '0;
        end else if (adv_en && r3_valid_reg) begin
            filt_lat_reg <= mix_lat[26:0];
            filt_lon_reg <= mix_lon[27:0];
        end
    end

    // Distance of the sample from the updated filter.
    always_comb begin
        dev_lat = 28'(r4_lat_reg) - 28'(filt_lat_reg);
        dev_lon = 29'(r4_lon_reg) - 29'(filt_lon_reg);
        abs_lat = dev_lat[27] ? 28'(-dev_lat) : 28'(dev_lat);
        abs_lon = dev_lon[28] ? 29'(-dev_lon) : 29'(dev_lon);
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_lat_reg  <= r4_lat_reg;
            out_lon_reg  <= r4_lon_reg;
            out_fix_reg  <= r4_fix_reg;
            out_sats_reg <= r4_sats_reg;
            out_hdop_reg <= r4_hdop_reg;
            out_alt_reg  <= r4_alt_reg;
            out_slat_reg <= filt_lat_reg;
            out_slon_reg <= filt_lon_reg;
            out_acc_reg  <= (abs_lat <= {1'b0, thresh_reg}) && (abs_lon <= {2'b0, thresh_reg});
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_latitude        = out_lat_reg;
    assign m_longitude       = out_lon_reg;
    assign m_fix_quality     = out_fix_reg;
    assign m_satellite_count = out_sats_reg;
    assign m_hdop_hundredths = out_hdop_reg;
    assign m_altitude_dm     = out_alt_reg;
    assign m_smoothed_lat    = out_slat_reg;
    assign m_smoothed_lon    = out_slon_reg;
    assign m_accepted        = out_acc_reg;

    // A GGA line is at least seven bytes, so only one line is ever in flight.
    a_one_line_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({r1_valid_reg, r2_valid_reg, r3_valid_reg, r4_valid_reg}))
        else $error("more than one line in the filter pipeline");

    // Input stalls exactly when a finished line cannot leave the last stage.
    a_stall_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        (r4_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while the last stage is blocked");

    // A finished GGA line enters the pipeline on the next edge.
    a_line_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        line_done |=> r1_valid_reg)
        else $error("finished line did not reach the first stage");

    // The filter moves only when a line passes the update stage.
    a_filter_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(r3_valid_reg && adv_en) |=> $stable(filt_lat_reg) && $stable(filt_lon_reg))
        else $error("filter changed without a line");

endmodule
